FILE: sv/lrukot_pkg.sv
// Shared constants for the LRU key order tracker.
package lrukot_pkg;

  localparam int unsigned DefaultEntries = 16;
  localparam int unsigned KeyWidth       = 64;
  localparam int unsigned CountOutWidth  = 5;

  // Request kind codes
  localparam logic KindTouch  = 1'b0;
  localparam logic KindRemove = 1'b1;

endpackage : lrukot_pkg

FILE: sv/lrukot_match.sv
// Parallel key lookup across the held slots.
module lrukot_match #(
  parameter int unsigned ENTRIES = lrukot_pkg::DefaultEntries,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
  input  logic [lrukot_pkg::KeyWidth-1:0]              key_i,
  input  logic [ENTRIES-1:0][lrukot_pkg::KeyWidth-1:0] slots_i,
  input  logic [CW-1:0]                                count_i,
  output logic                                         hit_o,
  output logic [IW-1:0]                                pos_o
);

  logic [ENTRIES-1:0] match;

  // Keys are distinct, so at most one slot matches.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (count_i > CW'(i)) && (slots_i[i] == key_i);
    end
  end

  always_comb begin
    pos_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        pos_o = pos_o | IW'(i);
      end
    end
  end

  assign hit_o = |match;

endmodule : lrukot_match

FILE: sv/lru_key_order_tracker.sv
// Top level of the LRU key order tracker.
// A request is captured in the request register and its result in the result register.
// Throughput: one request per cycle while the result channel is not stalled; lookup, slot
//   shift and count update are combinational between the request and result registers.
// Reset clears the pipeline valids and the held count; key slots are not reset
//   and are only read below the held count.
module lru_key_order_tracker #(
  parameter int unsigned ENTRIES = lrukot_pkg::DefaultEntries
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [lrukot_pkg::KeyWidth-1:0]     key_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                was_present_o,
  output logic                                accepted_o,
  output logic [lrukot_pkg::CountOutWidth-1:0] entry_count_o,
  output logic                                oldest_valid_o,
  output logic [lrukot_pkg::KeyWidth-1:0]     oldest_key_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned XW = CW + lrukot_pkg::CountOutWidth;
  localparam int unsigned KW = lrukot_pkg::KeyWidth;

  // ---------------------------------------------------------------------------
  // Request register
  // ---------------------------------------------------------------------------
  logic          req_valid_q;
  logic          req_kind_q;
  logic [KW-1:0] req_key_q;

  logic out_valid_q;
  logic out_ready;   // result register free or being drained this cycle
  logic fire;        // request register processed this cycle

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = req_valid_q && out_ready;
  assign in_stall_o = req_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      req_kind_q <= kind_i;
      req_key_q  <= key_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Ordered key slots: slot 0 oldest, slot count-1 newest
  // ---------------------------------------------------------------------------
  logic [ENTRIES-1:0][KW-1:0] slots_q, slots_d;
  logic [CW-1:0]              count_q, count_d;

  logic          hit;
  logic [IW-1:0] pos;

  lrukot_match #(
    .ENTRIES (ENTRIES)
  ) u_match (
    .key_i   (req_key_q),
    .slots_i (slots_q),
    .count_i (count_q),
    .hit_o   (hit),
    .pos_o   (pos)
  );

  logic          is_touch;
  logic          full;
  logic          accepted;
  logic          wr_en;
  logic [CW-1:0] wr_slot_w;
  logic [IW-1:0] wr_slot;

  assign is_touch  = (req_kind_q == lrukot_pkg::KindTouch);
  assign full      = (count_q == CW'(ENTRIES));
  // A new key meeting a full store is refused, nothing is evicted.
  assign accepted  = !(is_touch && !hit && full);
  assign wr_en     = is_touch && accepted;
  // After a hit the gap closes first, so the newest slot sits one lower.
  assign wr_slot_w = hit ? (count_q - CW'(1)) : count_q;
  assign wr_slot   = wr_slot_w[IW-1:0];

  always_comb begin
    count_d = count_q;
    if (!is_touch && hit) begin
      count_d = count_q - CW'(1);
    end else if (is_touch && !hit && !full) begin
      count_d = count_q + CW'(1);
    end
  end

  // Slots at or above a hit move down one; the touched key lands on top.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit && (pos <= IW'(i)) && (i + 1 < ENTRIES)) begin
        slots_d[i] = slots_q[(i + 1 < ENTRIES) ? i + 1 : i];
      end else begin
        slots_d[i] = slots_q[i];
      end
      if (wr_en && (wr_slot == IW'(i))) begin
        slots_d[i] = req_key_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      slots_q <= slots_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [XW-1:0] count_ext;
  assign count_ext = XW'(count_d);

  logic                                 was_present_q;
  logic                                 accepted_q;
  logic [lrukot_pkg::CountOutWidth-1:0] entry_count_q;
  logic                                 oldest_valid_q;
  logic [KW-1:0]                        oldest_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      was_present_q  <= hit;
      accepted_q     <= accepted;
      entry_count_q  <= count_ext[lrukot_pkg::CountOutWidth-1:0];
      oldest_valid_q <= (count_d != '0);
      oldest_key_q   <= (count_d != '0) ? slots_d[0] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign was_present_o  = was_present_q;
  assign accepted_o     = accepted_q;
  assign entry_count_o  = entry_count_q;
  assign oldest_valid_o = oldest_valid_q;
  assign oldest_key_o   = oldest_key_q;

endmodule : lru_key_order_tracker
